// ----- design/dec_pkg.sv -----
// Shared types and constants for the data EEPROM controller.
// Used by dec_array and data_eeprom_controller; depends on nothing else.
`default_nettype none

package dec_pkg;

  // Function codes of a request
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Register selects
  localparam logic [2:0] REG_ADDR_LO = 3'd0;
  localparam logic [2:0] REG_ADDR_HI = 3'd1;
  localparam logic [2:0] REG_DATA    = 3'd2;
  localparam logic [2:0] REG_CTRL    = 3'd3;
  localparam logic [2:0] REG_UNLOCK  = 3'd4;

  // Control register bit positions
  localparam int CTRL_PROG = 7;
  localparam int CTRL_CFGS = 6;
  localparam int CTRL_WREN = 2;
  localparam int CTRL_WR   = 1;
  localparam int CTRL_RD   = 0;

  // Unlock keys, erased byte, reset write time
  localparam logic [7:0] KEY_FIRST         = 8'h55;
  localparam logic [7:0] KEY_SECOND        = 8'hAA;
  localparam logic [7:0] ERASED_BYTE       = 8'hFF;
  localparam logic [7:0] WRITE_TICKS_RESET = 8'd4;

  // Configuration register index
  localparam logic CFG_WRITE_TICKS = 1'b0;

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] reg_sel;
    logic [7:0] wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       write_busy;
  } rsp_t;

  // Memory access strobes from the register file to the array
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- design/data_eeprom_controller.sv -----
// Data EEPROM controller: register file, unlock tracking, write timer, APB config.
// Depends on dec_pkg and dec_array.
//
// Usage:
//   Requests (bus read, bus write or time tick) enter on req when start is high
//   and busy is low. Each request gives one response on rsp in the next cycle,
//   marked by done for exactly one cycle; the receiver cannot hold it off.
//   A new request may be taken every cycle: each needs one pass through the
//   register update logic and at most one access to the byte array.
//   After reset busy stays high while the array is swept to 0xFF, one byte per
//   cycle; no request is taken then, though APB writes are. All registers but
//   the response register return to their reset values.
//   A data memory write starts from a control write with WR and WREN set and PROG
//   and CFGS clear after the 0x55, 0xAA unlock pair; rsp.write_busy then stays high
//   until the write_ticks-th tick request (the first if write_ticks is 0) stores the byte.
//   write_ticks lives at APB address 0 and should only change while idle.
//   A control RD loads the data register from the array; the byte appears in
//   the data register for the next request.
`default_nettype none

module data_eeprom_controller #(
  parameter int ADDR_BITS = 10
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  dec_pkg::req_t       req,
  output logic                done,
  output dec_pkg::rsp_t       rsp,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import dec_pkg::*;

  typedef enum logic [2:0] {
    ST_LOCKED = 3'b001,
    ST_KEY1   = 3'b010,
    ST_ARMED  = 3'b100
  } unlock_t;

  // State
  logic [ADDR_BITS-1:0] address, address_next;
  logic [7:0]           data_reg, data_reg_next;
  logic                 data_loaded, data_loaded_next;
  logic                 prog, prog_next;
  logic                 cfgs, cfgs_next;
  logic                 wren, wren_next;
  logic                 wbusy, wbusy_next;
  unlock_t              unlock, unlock_next;
  logic [7:0]           counter, counter_next;
  logic [7:0]           write_ticks;
  rsp_t                 rsp_next;

  logic                 accept;
  logic                 clearing;
  logic [7:0]           mem_rdata;
  logic [7:0]           data_eff;
  mem_ctl_t             mem_ctl;
  logic                 armed;
  logic                 data_mem;

  assign accept   = start && !busy;
  assign busy     = clearing;
  // Data register reads through to the array output after a RD load
  assign data_eff = data_loaded ? mem_rdata : data_reg;

  dec_array #(
    .ADDR_BITS(ADDR_BITS)
  ) u_array (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mem_ctl),
    .addr     (address),
    .wdata    (data_eff),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  // APB configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_WRITE_TICKS) ? {24'd0, write_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ticks <= WRITE_TICKS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == CFG_WRITE_TICKS) begin
      write_ticks <= pwdata[7:0];
    end
  end

  // Request handling
  always_comb begin
    address_next     = address;
    data_reg_next    = data_reg;
    data_loaded_next = data_loaded;
    prog_next        = prog;
    cfgs_next        = cfgs;
    wren_next        = wren;
    wbusy_next       = wbusy;
    unlock_next      = unlock;
    counter_next     = counter;
    mem_ctl          = '0;
    rsp_next         = '0;
    armed            = (unlock == ST_ARMED);
    data_mem         = 1'b0;

    if (accept) begin
      case (req.func)
        FUNC_READ: begin
          unique case (req.reg_sel)
            REG_ADDR_LO: rsp_next.rdata = address[7:0];
            REG_ADDR_HI: rsp_next.rdata = 8'(address >> 8);
            REG_DATA:    rsp_next.rdata = data_eff;
            REG_CTRL:    rsp_next.rdata = {prog, cfgs, 3'b000, wren, wbusy, 1'b0};
            default:     rsp_next.rdata = 8'd0;
          endcase
        end
        FUNC_WRITE: begin
          unique case (req.reg_sel)
            REG_ADDR_LO: begin
              unlock_next = ST_LOCKED;
              if (!wbusy) begin
                address_next = ADDR_BITS'({address >> 8, req.wdata});
              end
            end
            REG_ADDR_HI: begin
              unlock_next = ST_LOCKED;
              if (!wbusy) begin
                address_next = ADDR_BITS'({req.wdata, address[7:0]});
              end
            end
            REG_DATA: begin
              unlock_next = ST_LOCKED;
              if (!wbusy) begin
                data_reg_next    = req.wdata;
                data_loaded_next = 1'b0;
              end
            end
            REG_CTRL: begin
              unlock_next = ST_LOCKED;
              prog_next   = req.wdata[CTRL_PROG];
              cfgs_next   = req.wdata[CTRL_CFGS];
              wren_next   = req.wdata[CTRL_WREN];
              data_mem    = !req.wdata[CTRL_PROG] && !req.wdata[CTRL_CFGS];
              if (!wbusy) begin
                if (req.wdata[CTRL_WR] && armed && data_mem && req.wdata[CTRL_WREN]) begin
                  wbusy_next   = 1'b1;
                  counter_next = (write_ticks != 8'd0) ? write_ticks : 8'd1;
                end else if (req.wdata[CTRL_RD] && data_mem) begin
                  mem_ctl.rd       = 1'b1;
                  data_loaded_next = 1'b1;
                end
              end
            end
            REG_UNLOCK: begin
              if (req.wdata == KEY_FIRST) begin
                unlock_next = ST_KEY1;
              end else if (req.wdata == KEY_SECOND && unlock == ST_KEY1) begin
                unlock_next = ST_ARMED;
              end else begin
                unlock_next = ST_LOCKED;
              end
            end
            default: begin
              // undefined selects change nothing
            end
          endcase
        end
        FUNC_TICK: begin
          if (wbusy) begin
            if (counter > 8'd1) begin
              counter_next = counter - 8'd1;
            end else begin
              counter_next = 8'd0;
              mem_ctl.wr   = 1'b1;
              wbusy_next   = 1'b0;
            end
          end
        end
        default: begin
          // undefined function: no operation
        end
      endcase
      rsp_next.write_busy = wbusy_next;
    end
  end

  // Control and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      address     <= '0;
      data_reg    <= 8'd0;
      data_loaded <= 1'b0;
      prog        <= 1'b0;
      cfgs        <= 1'b0;
      wren        <= 1'b0;
      wbusy       <= 1'b0;
      unlock      <= ST_LOCKED;
      counter     <= 8'd0;
      done        <= 1'b0;
    end else begin
      address     <= address_next;
      data_reg    <= data_reg_next;
      data_loaded <= data_loaded_next;
      prog        <= prog_next;
      cfgs        <= cfgs_next;
      wren        <= wren_next;
      wbusy       <= wbusy_next;
      unlock      <= unlock_next;
      counter     <= counter_next;
      done        <= accept;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Every accepted request gives a response in the next cycle
  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("accepted request produced no response");

  // No response appears without a request the cycle before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("response without an accepted request");

  // Reported busy flag follows the write timer state
  a_busy_match: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.write_busy == wbusy))
    else $error("write_busy does not match the write timer");

  // A started programming cycle always has time left on the timer
  a_timer_loaded: assert property (@(posedge clk) disable iff (rst)
    $rose(wbusy) |-> (counter != 8'd0))
    else $error("write cycle started with an empty timer");

endmodule

`default_nettype wire

// ----- design/dec_array.sv -----
// EEPROM byte array with a clearing sweep after reset and a registered read port.
// Depends on dec_pkg.
`default_nettype none

module dec_array #(
  parameter int ADDR_BITS = 10
) (
  input  wire                      clk,
  input  wire                      rst,
  input  dec_pkg::mem_ctl_t        ctl,
  input  wire  [ADDR_BITS-1:0]     addr,
  input  wire  [7:0]               wdata,
  output logic [7:0]               rdata,
  output logic                     clearing
);
  import dec_pkg::*;

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [7:0]           mem [DEPTH];
  logic [ADDR_BITS-1:0] clr_addr;

  // Erase sweep: one byte per cycle from address zero to the top
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == {ADDR_BITS{1'b1}}) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Write port: sweep or programming cycle end
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= ERASED_BYTE;
    end else if (ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_data_eeprom_controller.sv -----
// Self-checking testbench for data_eeprom_controller: directed table, then random requests.
// Responses are compared with an in-bench model of the register file, unlock and write timer.
// Depends on dec_pkg and the data_eeprom_controller RTL (with its dec_array) only.

module tb_data_eeprom_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import dec_pkg::*;

  localparam int          ADDR_BITS        = 10;
  localparam int          MEM_WORDS        = 1 << ADDR_BITS;
  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int          PHASE_REQUESTS   = 140;
  localparam logic [1:0]  FUNC_NONE        = 2'd3;
  localparam logic [2:0]  REG_UNDEF_FIRST  = 3'd5;
  localparam logic [2:0]  REG_UNDEF_LAST   = 3'd7;
  localparam logic [2:0]  WRITE_TICKS_ADDR = {CFG_WRITE_TICKS, 2'b00};
  localparam logic [1:0]  UNLOCK_LOCKED    = 2'd0;
  localparam logic [1:0]  UNLOCK_KEY1      = 2'd1;
  localparam logic [1:0]  UNLOCK_ARMED     = 2'd2;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  req_t        req     = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        done;
  rsp_t        rsp;
  logic [31:0] prdata;
  logic        pready;

  // Model state of the EEPROM block
  logic [7:0]           mem_image [MEM_WORDS];
  logic [ADDR_BITS-1:0] addr_q;
  logic [7:0]           data_q;
  logic                 prog_q, cfgs_q, wren_q;
  logic                 busy_q;
  logic [1:0]           unlock_q;
  logic [7:0]           count_q;
  logic [7:0]           ticks_cfg;

  rsp_t        pending_rsp [$];
  dir_row_t    dir_rows [$];
  int          err_count    = 0;
  int          item_count   = 0;
  int          commit_count = 0;
  int          rsp_checked  = 0;
  int          idle_pct     = 0;
  int unsigned cycle_count  = 0;

  data_eeprom_controller #(.ADDR_BITS(ADDR_BITS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit, %0d responses still due", $time,
               pending_rsp.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One request applied to the model; returns the response it should give
  function automatic rsp_t eeprom_step(input req_t r);
    rsp_t o;
    logic armed;
    o = '0;
    case (r.func)
      FUNC_READ: begin
        case (r.reg_sel)
          REG_ADDR_LO: o.rdata = addr_q[7:0];
          REG_ADDR_HI: o.rdata = 8'(addr_q >> 8);
          REG_DATA:    o.rdata = data_q;
          REG_CTRL:    o.rdata = {prog_q, cfgs_q, 3'b000, wren_q, busy_q, 1'b0};
          default:     o.rdata = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (r.reg_sel)
          REG_ADDR_LO: begin
            unlock_q = UNLOCK_LOCKED;
            if (!busy_q) addr_q[7:0] = r.wdata;
          end
          REG_ADDR_HI: begin
            unlock_q = UNLOCK_LOCKED;
            if (!busy_q) addr_q[ADDR_BITS-1:8] = r.wdata[ADDR_BITS-9:0];
          end
          REG_DATA: begin
            unlock_q = UNLOCK_LOCKED;
            if (!busy_q) data_q = r.wdata;
          end
          REG_CTRL: begin
            // stage is checked first, then dropped; mode bits take effect at once
            armed    = (unlock_q == UNLOCK_ARMED);
            unlock_q = UNLOCK_LOCKED;
            prog_q   = r.wdata[CTRL_PROG];
            cfgs_q   = r.wdata[CTRL_CFGS];
            wren_q   = r.wdata[CTRL_WREN];
            if (!busy_q) begin
              if (r.wdata[CTRL_WR] && armed && !prog_q && !cfgs_q && wren_q) begin
                busy_q  = 1'b1;
                count_q = (ticks_cfg == 8'd0) ? 8'd1 : ticks_cfg;
              end else if (r.wdata[CTRL_RD] && !prog_q && !cfgs_q) begin
                data_q = mem_image[addr_q];
              end
            end
          end
          REG_UNLOCK: begin
            if (r.wdata == KEY_FIRST) unlock_q = UNLOCK_KEY1;
            else if (r.wdata == KEY_SECOND && unlock_q == UNLOCK_KEY1) unlock_q = UNLOCK_ARMED;
            else unlock_q = UNLOCK_LOCKED;
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (busy_q) begin
          if (count_q > 8'd1) begin
            count_q = count_q - 8'd1;
          end else begin
            count_q             = '0;
            mem_image[addr_q]   = data_q;
            busy_q              = 1'b0;
            commit_count++;
          end
        end
      end
      default: ;
    endcase
    o.write_busy = busy_q;
    return o;
  endfunction

  // Present one request, hold it until taken, queue its expected response
  task automatic issue(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    predicted = eeprom_step(r);
    pending_rsp.push_back(typed ? want : predicted);
    if (r.func != FUNC_NONE) item_count++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send(input logic [1:0] f, input logic [2:0] sel, input logic [7:0] wd);
    req_t r;
    r.func    = f;
    r.reg_sel = sel;
    r.wdata   = wd;
    issue(r, 1'b0, '0);
  endtask

  task automatic send_noise();
    logic [7:0] v;
    case ($urandom_range(0, 5))
      0:       v = KEY_FIRST;
      1:       v = KEY_SECOND;
      default: v = 8'($urandom);
    endcase
    send(2'($urandom), 3'($urandom), v);
  endtask

  task automatic add_row(input logic [1:0] f, input logic [2:0] sel, input logic [7:0] wd,
                         input bit typed, input logic [7:0] rd, input logic wb);
    dir_row_t row;
    row.r.func            = f;
    row.r.reg_sel         = sel;
    row.r.wdata           = wd;
    row.typed             = typed;
    row.want.rdata        = rd;
    row.want.write_busy   = wb;
    dir_rows.push_back(row);
  endtask

  // Stop sending until every response has come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // APB write of write_ticks, then a read back in the following transfer
  task automatic cfg_write_ticks(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WRITE_TICKS_ADDR;
    pwdata  <= {24'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ticks_cfg = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {24'b0, v}) begin
      $display("%0t: write_ticks read back: expected %08h, got %08h", $time, {24'b0, v}, prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Address, data, unlock pair, WR, ticks to completion, then read back; some runs broken
  task automatic write_cycle_seq();
    logic [ADDR_BITS-1:0] where;
    logic [7:0]           ctl;
    int                   flavour;
    case ($urandom_range(0, 3))
      0:       where = ADDR_BITS'($urandom_range(0, 7));
      1:       where = $urandom_range(0, 1) ? '0 : '1;
      default: where = ADDR_BITS'($urandom);
    endcase
    flavour = $urandom_range(0, 11);
    send(FUNC_WRITE, REG_ADDR_LO, where[7:0]);
    send(FUNC_WRITE, REG_ADDR_HI, {6'($urandom), where[ADDR_BITS-1:8]});
    send(FUNC_WRITE, REG_DATA, 8'($urandom));
    send(FUNC_WRITE, REG_UNLOCK, KEY_FIRST);
    // between the keys: a defined write breaks the pair, undefined writes and reads do not
    if (flavour == 0) send(FUNC_WRITE, REG_DATA, 8'($urandom));
    if (flavour == 1) send(FUNC_WRITE, 3'($urandom_range(REG_UNDEF_FIRST, REG_UNDEF_LAST)),
                           8'($urandom));
    if (flavour == 2) send(FUNC_READ, 3'($urandom), 8'($urandom));
    send(FUNC_WRITE, REG_UNLOCK, (flavour == 3) ? 8'($urandom) : KEY_SECOND);
    ctl = {2'b00, 3'($urandom), 1'b1, 1'b1, 1'($urandom)};
    if (flavour == 4) ctl[CTRL_WREN] = 1'b0;
    if (flavour == 5) ctl[CTRL_PROG] = 1'b1;
    if (flavour == 6) ctl[CTRL_CFGS] = 1'b1;
    send(FUNC_WRITE, REG_CTRL, ctl);
    // ticks carry random payload; other traffic during the cycle must not change the byte being written
    while (busy_q) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else send(FUNC_TICK, 3'($urandom), 8'($urandom));
    end
    send(FUNC_WRITE, REG_CTRL, 8'(1 << CTRL_RD));
    send(FUNC_READ, REG_DATA, 8'($urandom));
    send(FUNC_READ, REG_CTRL, 8'($urandom));
  endtask

  // Response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with nothing pending: expected none, got rdata=%02h busy=%0b",
                 $time, rsp.rdata, rsp.write_busy);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        rsp_checked++;
        if (rsp.rdata !== want.rdata) begin
          $display("%0t: rdata: expected %02h, got %02h", $time, want.rdata, rsp.rdata);
          err_count++;
        end
        if (rsp.write_busy !== want.write_busy) begin
          $display("%0t: write_busy: expected %0b, got %0b", $time, want.write_busy,
                   rsp.write_busy);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [7:0] tick_settings [5];
    int         target;

    for (int i = 0; i < MEM_WORDS; i++) mem_image[i] = ERASED_BYTE;
    addr_q    = '0;
    data_q    = '0;
    prog_q    = 1'b0;
    cfgs_q    = 1'b0;
    wren_q    = 1'b0;
    busy_q    = 1'b0;
    unlock_q  = UNLOCK_LOCKED;
    count_q   = '0;
    ticks_cfg = WRITE_TICKS_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table, reset write time of four ticks
    add_row(FUNC_READ,  REG_ADDR_LO,    8'h00, 1, 8'h00, 1'b0);
    add_row(FUNC_READ,  REG_CTRL,       8'hFF, 1, 8'h00, 1'b0);
    add_row(FUNC_READ,  REG_UNLOCK,     8'h00, 1, 8'h00, 1'b0);
    add_row(FUNC_READ,  REG_UNDEF_LAST, 8'hFF, 1, 8'h00, 1'b0);
    add_row(FUNC_NONE,  REG_UNDEF_LAST, 8'hFF, 1, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_ADDR_LO,    8'hFF, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_ADDR_HI,    8'hFF, 0, 8'h00, 1'b0);
    add_row(FUNC_READ,  REG_ADDR_HI,    8'h00, 1, 8'h03, 1'b0);   // two bits kept
    add_row(FUNC_WRITE, REG_CTRL,       8'h01, 0, 8'h00, 1'b0);   // RD of top byte
    add_row(FUNC_READ,  REG_DATA,       8'h00, 1, ERASED_BYTE, 1'b0);
    add_row(FUNC_WRITE, REG_DATA,       8'h00, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_UNLOCK,     KEY_FIRST, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_UNDEF_FIRST, 8'h00, 0, 8'h00, 1'b0);  // stage survives
    add_row(FUNC_WRITE, REG_UNLOCK,     KEY_SECOND, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_CTRL,       8'hC6, 1, 8'h00, 1'b0);   // not data memory
    add_row(FUNC_WRITE, REG_UNLOCK,     KEY_FIRST, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_UNLOCK,     KEY_SECOND, 0, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_CTRL,       8'h07, 1, 8'h00, 1'b1);   // WR wins over RD
    add_row(FUNC_WRITE, REG_DATA,       8'h12, 0, 8'h00, 1'b1);   // ignored while busy
    add_row(FUNC_READ,  REG_CTRL,       8'h00, 1, 8'h06, 1'b1);
    add_row(FUNC_TICK,  REG_UNDEF_LAST, 8'hFF, 0, 8'h00, 1'b0);
    add_row(FUNC_TICK,  REG_ADDR_LO,    8'h00, 0, 8'h00, 1'b0);
    add_row(FUNC_TICK,  REG_CTRL,       8'h02, 0, 8'h00, 1'b0);
    add_row(FUNC_TICK,  REG_UNLOCK,     8'hAA, 1, 8'h00, 1'b0);
    add_row(FUNC_WRITE, REG_CTRL,       8'h01, 0, 8'h00, 1'b0);
    add_row(FUNC_READ,  REG_DATA,       8'hFF, 1, 8'h00, 1'b0);
    foreach (dir_rows[i]) issue(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].want);
    wait_drained();

    // Random phases over several write times, the extremes included
    tick_settings[0] = 8'd1;
    tick_settings[1] = 8'd0;
    tick_settings[2] = 8'd255;
    tick_settings[3] = 8'($urandom_range(2, 12));
    tick_settings[4] = 8'd3;
    for (int p = 0; p < 5; p++) begin
      cfg_write_ticks(tick_settings[p]);
      idle_pct = (p == 4) ? 0 : $urandom_range(5, 30);
      target   = item_count + PHASE_REQUESTS;
      while (item_count < target) begin
        if ($urandom_range(0, 9) < 6) write_cycle_seq();
        else repeat ($urandom_range(1, 6)) send_noise();
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      // let any running cycle finish before the write time changes
      while (busy_q) send(FUNC_TICK, 3'($urandom), 8'($urandom));
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Run covered %0d requests over 6 write time settings, %0d responses checked,",
             item_count, rsp_checked);
    $display("with %0d EEPROM bytes committed through the unlock sequence.", commit_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
